// ===== design/amnm_pkg.sv =====
// Shared types, constants and table-building functions for the AMPA/NMDA synapse step unit.
`default_nettype none

package amnm_pkg;

	// Field and datapath widths
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int V_W        = 16;
	localparam int W_W        = 16;
	localparam int G_W        = 32;
	localparam int F_W        = 16;
	localparam int MG_W       = 17;
	localparam int OUT_W      = 48;
	localparam int TICK_W     = 24;
	localparam int DRV_W      = V_W + 1;
	localparam int MUL_A_W    = G_W + 1;
	localparam int MUL_B_W    = MG_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int T_W        = 42;
	localparam int HI_SHIFT   = 24;
	localparam int HI_W       = T_W - HI_SHIFT;
	localparam int ACC_W      = 60;
	localparam int W_FRAC     = 8;
	localparam int MG_FRAC    = 16;
	localparam int SUM_W      = ACC_W - W_FRAC;

	// Default parameter values
	localparam int MG_TABLE_DEPTH_DEF     = 256;
	localparam int MG_CONC_MILLIMOLAR_DEF = 1;

	// Magnesium block: 0.062 * log2(e) in Q24
	localparam longint EXP_K = 64'sd1500673;

	// Output saturation bounds at sum width
	localparam logic signed [SUM_W-1:0] SUM_OUT_MAX =
		{{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_OUT_MIN =
		{{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AMPA_STEP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NMDA_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSAL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMPA_RISE_FAC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AMPA_FALL_FAC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NMDA_RISE_FAC  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NMDA_FALL_FAC  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TICKS = 3'd7;

	// Sequencer state
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Micro-operation kinds of the shared multiplier sequence
	typedef enum logic [2:0] {
		U_DECAY = 3'd0,
		U_STEP  = 3'd1,
		U_DIFF  = 3'd2,
		U_DRV   = 3'd3,
		U_LO    = 3'd4,
		U_HI_T  = 3'd5,
		U_HI_W  = 3'd6,
		U_ADD   = 3'd7
	} uop_kind_t;

	// Conductance selector
	typedef enum logic [1:0] {
		G_AMPA_RISE = 2'd0,
		G_AMPA_FALL = 2'd1,
		G_NMDA_RISE = 2'd2,
		G_NMDA_FALL = 2'd3
	} gsel_t;

	typedef struct packed {
		uop_kind_t kind;
		gsel_t     sel;
		logic      nmda;
		logic      use_mg;
	} uop_t;

	localparam int TICK_LEN  = 16;
	localparam int SPIKE_LEN = 4;
	localparam int UOP_W     = $clog2(TICK_LEN);
	localparam int SPIKE_IW  = $clog2(SPIKE_LEN);
	localparam logic [UOP_W-1:0] TICK_LAST  = UOP_W'(TICK_LEN - 1);
	localparam logic [UOP_W-1:0] SPIKE_LAST = UOP_W'(SPIKE_LEN - 1);

	// One result step: decay, AMPA term, NMDA term with block, sum
	localparam uop_t TICK_PROG [TICK_LEN] = '{
		'{kind: U_DECAY, sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DECAY, sel: G_AMPA_FALL, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DECAY, sel: G_NMDA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DECAY, sel: G_NMDA_FALL, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DIFF,  sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DRV,   sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_LO,    sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_HI_W,  sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_ADD,   sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_DIFF,  sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b0},
		'{kind: U_DRV,   sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b0},
		'{kind: U_LO,    sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b1},
		'{kind: U_HI_T,  sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b1},
		'{kind: U_LO,    sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b0},
		'{kind: U_HI_W,  sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b0},
		'{kind: U_ADD,   sel: G_AMPA_RISE, nmda: 1'b1, use_mg: 1'b0}
	};

	// Spike: step all four conductances of both result steps
	localparam uop_t SPIKE_PROG [SPIKE_LEN] = '{
		'{kind: U_STEP, sel: G_AMPA_RISE, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_STEP, sel: G_AMPA_FALL, nmda: 1'b0, use_mg: 1'b0},
		'{kind: U_STEP, sel: G_NMDA_RISE, nmda: 1'b1, use_mg: 1'b0},
		'{kind: U_STEP, sel: G_NMDA_FALL, nmda: 1'b1, use_mg: 1'b0}
	};

	// Add two conductances, clamp at full scale
	function automatic logic [G_W-1:0] sat_add_g(input logic [G_W-1:0] a,
		input logic [G_W-1:0] b);
		logic [G_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[G_W] ? {G_W{1'b1}} : s[G_W-1:0];
	endfunction

	// Clamp the summed current to the output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] s);
		logic signed [OUT_W-1:0] r;
		if (s > SUM_OUT_MAX) begin
			r = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (s < SUM_OUT_MIN) begin
			r = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = s[OUT_W-1:0];
		end
		return r;
	endfunction

	// Digit-by-digit integer square root, elaboration only
	function automatic longint unsigned isqrt64(input longint unsigned x_in);
		longint unsigned x;
		longint unsigned r;
		longint unsigned b;
		int it;
		x = x_in;
		r = 0;
		b = 64'd1 << 62;
		for (it = 0; it < 32; it++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	typedef longint unsigned roots_t [16];

	// Q30 constants 2^(2^-(j+1)) by repeated square roots
	function automatic roots_t mg_roots_build();
		roots_t rt;
		longint unsigned prev;
		int j;
		prev = 64'd1 << 31;
		for (j = 0; j < 16; j++) begin
			prev = isqrt64(prev << 30);
			rt[j] = prev;
		end
		return rt;
	endfunction

	localparam roots_t MG_ROOTS = mg_roots_build();

	// Block denominator 1 + [Mg]/3.57 * exp(-0.062 V) in Q16 for one table voltage
	function automatic longint unsigned mg_den(input longint vq_off,
		input longint unsigned mgq);
		longint vq;
		longint e;
		longint n;
		longint sh;
		longint unsigned f;
		longint unsigned m;
		longint unsigned pw;
		int j;
		vq = vq_off - 64'sd32768;
		e = (-vq * EXP_K) >>> 16;
		n = e >>> 16;
		f = longint'(e - (n <<< 16));
		m = 64'd1 << 30;
		for (j = 0; j < 16; j++) begin
			if (f[15-j]) begin
				m = (m * MG_ROOTS[j]) >> 30;
			end
		end
		sh = 64'sd14 - n;
		if (sh < 0) begin
			sh = 0;
		end
		pw = (sh > 63) ? 64'd0 : (m >> sh);
		return 64'd65536 + ((pw * mgq) >> 16);
	endfunction

endpackage

`default_nettype wire

// ===== design/ampa_nmda_synapse_step_unit.sv =====
// AMPA/NMDA dual-exponential synapse step unit with magnesium block, one shared multiplier.
`default_nettype none

// One synapse with rise/fall AMPA and NMDA conductances for the current and the next
// step. A spike item (operation 1) adds the peak steps; a tick item (operation 0) on
// an active synapse decays all eight conductances and returns both weighted currents,
// the NMDA part scaled by a voltage-indexed magnesium-block table (an inactive tick
// returns zeros). All arithmetic runs through one 33x18 signed multiplier whose
// product is registered. No item is taken until the last is handed off: a tick on an
// active synapse runs two result steps through the sequencer, a spike runs the spike
// program, and a tick on an inactive synapse goes straight to the hand-off to the
// output register. That register holds one finished result, so a stalled output lets
// the next item finish but holds it, with the input stalled, until the hand-off. The
// magnesium table is a constant ROM built at elaboration with a registered read;
// there is no clearing pass after reset.
module ampa_nmda_synapse_step_unit #(
	parameter int MG_TABLE_DEPTH     = amnm_pkg::MG_TABLE_DEPTH_DEF,
	parameter int MG_CONC_MILLIMOLAR = amnm_pkg::MG_CONC_MILLIMOLAR_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [amnm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [amnm_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  wire logic                                 in_valid,
	output      logic                                 in_stall,
	input  wire logic                                 operation,
	input  wire logic signed [amnm_pkg::V_W-1:0]      v_now,
	input  wire logic signed [amnm_pkg::V_W-1:0]      v_next,
	input  wire logic [amnm_pkg::W_W-1:0]             syn_weight,
	// output channel
	output      logic                                 out_valid,
	input  wire logic                                 out_stall,
	output      logic signed [amnm_pkg::OUT_W-1:0]    current_now,
	output      logic signed [amnm_pkg::OUT_W-1:0]    current_next,
	output      logic                                 is_active
);

	localparam int IDX_W = (MG_TABLE_DEPTH > 1) ? $clog2(MG_TABLE_DEPTH) : 1;
	localparam int DEP_W = $clog2(MG_TABLE_DEPTH + 1);
	localparam int IP_W  = amnm_pkg::V_W + DEP_W;
	localparam longint unsigned MG_Q =
		(longint'(MG_CONC_MILLIMOLAR) * 64'd6553600 + 64'd178) / 64'd357;

	// Configuration registers
	logic [amnm_pkg::G_W-1:0]        ampa_step_q;
	logic [amnm_pkg::G_W-1:0]        nmda_step_q;
	logic signed [amnm_pkg::V_W-1:0] reversal_q;
	logic [amnm_pkg::F_W-1:0]        ampa_rise_fac_q;
	logic [amnm_pkg::F_W-1:0]        ampa_fall_fac_q;
	logic [amnm_pkg::F_W-1:0]        nmda_rise_fac_q;
	logic [amnm_pkg::F_W-1:0]        nmda_fall_fac_q;
	logic [amnm_pkg::TICK_W-1:0]     shutdown_q;

	// Synapse state
	logic [amnm_pkg::G_W-1:0]        ampa_rise_g_q [2];
	logic [amnm_pkg::G_W-1:0]        ampa_fall_g_q [2];
	logic [amnm_pkg::G_W-1:0]        nmda_rise_g_q [2];
	logic [amnm_pkg::G_W-1:0]        nmda_fall_g_q [2];
	logic [amnm_pkg::TICK_W-1:0]     ticks_q;
	logic                            active_q;

	// Sequencer
	amnm_pkg::state_t                state_q;
	logic                            mode_spike_q;
	logic                            k_q;
	logic [amnm_pkg::UOP_W-1:0]      uop_q;
	logic                            phase_q;

	// Item and working registers
	logic signed [amnm_pkg::V_W-1:0]     v_now_q;
	logic signed [amnm_pkg::V_W-1:0]     v_next_q;
	logic [amnm_pkg::W_W-1:0]            w_q;
	logic signed [amnm_pkg::MUL_A_W-1:0] diff_q;
	logic signed [amnm_pkg::DRV_W-1:0]   drive_q;
	logic signed [amnm_pkg::T_W-1:0]     t_q;
	logic signed [amnm_pkg::ACC_W-1:0]   acc_q;
	logic signed [amnm_pkg::SUM_W-1:0]   sum_q;
	logic signed [amnm_pkg::PROD_W-1:0]  prod_q;
	logic signed [amnm_pkg::OUT_W-1:0]   cur_q [2];
	logic [IDX_W-1:0]                    idx_q;
	logic [amnm_pkg::MG_W-1:0]           mg_q;

	// Output register
	logic                                out_valid_q;
	logic signed [amnm_pkg::OUT_W-1:0]   current_now_q;
	logic signed [amnm_pkg::OUT_W-1:0]   current_next_q;
	logic                                is_active_q;

	// Combinational datapath
	amnm_pkg::uop_t                      uop;
	logic                                is_mult;
	logic                                uop_last;
	logic                                exec;
	logic                                in_take;
	logic                                out_load;
	logic signed [amnm_pkg::V_W-1:0]     v_sel;
	logic [amnm_pkg::G_W-1:0]            g_sel0;
	logic [amnm_pkg::G_W-1:0]            g_sel1;
	logic [amnm_pkg::G_W-1:0]            g_cur;
	logic [amnm_pkg::F_W-1:0]            fac_cur;
	logic [amnm_pkg::G_W-1:0]            step_cur;
	logic [amnm_pkg::G_W-1:0]            rise_cur;
	logic [amnm_pkg::G_W-1:0]            fall_cur;
	logic                                b_mg;
	logic signed [amnm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [amnm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [amnm_pkg::PROD_W-1:0]  mul_p;
	logic [amnm_pkg::G_W-1:0]            g_dec;
	logic signed [amnm_pkg::ACC_W-1:0]   prod_ext;
	logic signed [amnm_pkg::ACC_W-1:0]   acc_hi_sum;
	logic signed [amnm_pkg::SUM_W-1:0]   acc_term;
	logic signed [amnm_pkg::SUM_W-1:0]   sum_total;
	logic [amnm_pkg::TICK_W-1:0]         ticks_next;
	logic [amnm_pkg::V_W-1:0]            v_off;
	logic [IP_W-1:0]                     idx_prod;
	logic [amnm_pkg::MG_W-1:0]           mg_rom [MG_TABLE_DEPTH];

	// Build the magnesium block table at elaboration
	for (genvar gi = 0; gi < MG_TABLE_DEPTH; gi++) begin : g_mg_rom
		localparam longint VQ_OFF = (longint'(gi) * 64'sd65536) / MG_TABLE_DEPTH;
		localparam longint unsigned DEN = amnm_pkg::mg_den(VQ_OFF, MG_Q);
		localparam longint unsigned ENTRY = ((64'd1 << 32) + DEN / 2) / DEN;
		assign mg_rom[gi] = amnm_pkg::MG_W'(ENTRY);
	end

	// Handshake
	assign in_stall     = (state_q != amnm_pkg::ST_IDLE);
	assign in_take      = in_valid && !in_stall;
	assign out_load     = (state_q == amnm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid    = out_valid_q;
	assign current_now  = current_now_q;
	assign current_next = current_next_q;
	assign is_active    = is_active_q;

	// Decode the current micro-operation
	assign uop = mode_spike_q ? amnm_pkg::SPIKE_PROG[uop_q[amnm_pkg::SPIKE_IW-1:0]]
		: amnm_pkg::TICK_PROG[uop_q];
	assign is_mult  = (uop.kind != amnm_pkg::U_DIFF) && (uop.kind != amnm_pkg::U_ADD);
	assign uop_last = mode_spike_q ? (uop_q == amnm_pkg::SPIKE_LAST)
		: (uop_q == amnm_pkg::TICK_LAST);
	assign exec     = (state_q == amnm_pkg::ST_RUN) && (!is_mult || phase_q);
	assign v_sel    = k_q ? v_next_q : v_now_q;
	assign b_mg     = uop.use_mg || (uop.kind == amnm_pkg::U_HI_T);

	// Select the conductance, factor and step addressed by the operation
	always_comb begin
		unique case (uop.sel)
			amnm_pkg::G_AMPA_RISE: begin
				g_sel0   = ampa_rise_g_q[0];
				g_sel1   = ampa_rise_g_q[1];
				fac_cur  = ampa_rise_fac_q;
				step_cur = ampa_step_q;
			end
			amnm_pkg::G_AMPA_FALL: begin
				g_sel0   = ampa_fall_g_q[0];
				g_sel1   = ampa_fall_g_q[1];
				fac_cur  = ampa_fall_fac_q;
				step_cur = ampa_step_q;
			end
			amnm_pkg::G_NMDA_RISE: begin
				g_sel0   = nmda_rise_g_q[0];
				g_sel1   = nmda_rise_g_q[1];
				fac_cur  = nmda_rise_fac_q;
				step_cur = nmda_step_q;
			end
			amnm_pkg::G_NMDA_FALL: begin
				g_sel0   = nmda_fall_g_q[0];
				g_sel1   = nmda_fall_g_q[1];
				fac_cur  = nmda_fall_fac_q;
				step_cur = nmda_step_q;
			end
		endcase
	end

	assign g_cur    = k_q ? g_sel1 : g_sel0;
	assign rise_cur = uop.nmda ? nmda_rise_g_q[k_q] : ampa_rise_g_q[k_q];
	assign fall_cur = uop.nmda ? nmda_fall_g_q[k_q] : ampa_fall_g_q[k_q];

	// Steer the shared multiplier operands
	always_comb begin
		unique case (uop.kind)
			amnm_pkg::U_DECAY: begin
				mul_a = {1'b0, g_cur};
				mul_b = {2'b00, fac_cur};
			end
			amnm_pkg::U_STEP: begin
				mul_a = {1'b0, step_cur};
				mul_b = {2'b00, fac_cur};
			end
			amnm_pkg::U_DRV: begin
				mul_a = diff_q;
				mul_b = {drive_q[amnm_pkg::DRV_W-1], drive_q};
			end
			amnm_pkg::U_LO: begin
				mul_a = {{(amnm_pkg::MUL_A_W-amnm_pkg::HI_SHIFT){1'b0}},
					t_q[amnm_pkg::HI_SHIFT-1:0]};
				mul_b = b_mg ? {1'b0, mg_q} : {2'b00, w_q};
			end
			amnm_pkg::U_HI_T, amnm_pkg::U_HI_W: begin
				mul_a = {{(amnm_pkg::MUL_A_W-amnm_pkg::HI_W){t_q[amnm_pkg::T_W-1]}},
					t_q[amnm_pkg::T_W-1:amnm_pkg::HI_SHIFT]};
				mul_b = b_mg ? {1'b0, mg_q} : {2'b00, w_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Post-multiply shaping
	assign g_dec      = prod_q[amnm_pkg::G_W+amnm_pkg::F_W-1:amnm_pkg::F_W];
	assign prod_ext   = {{(amnm_pkg::ACC_W-amnm_pkg::PROD_W){prod_q[amnm_pkg::PROD_W-1]}},
		prod_q};
	assign acc_hi_sum = acc_q + (prod_ext <<< amnm_pkg::HI_SHIFT);
	assign acc_term   = acc_q[amnm_pkg::ACC_W-1:amnm_pkg::W_FRAC];
	assign sum_total  = sum_q + acc_term;
	assign ticks_next = (ticks_q == {amnm_pkg::TICK_W{1'b1}}) ? ticks_q : ticks_q + 1'b1;

	// Table index from the selected voltage
	assign v_off    = {~v_sel[amnm_pkg::V_W-1], v_sel[amnm_pkg::V_W-2:0]};
	assign idx_prod = IP_W'(v_off) * IP_W'(MG_TABLE_DEPTH);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ampa_step_q     <= '0;
			nmda_step_q     <= '0;
			reversal_q      <= '0;
			ampa_rise_fac_q <= '1;
			ampa_fall_fac_q <= '1;
			nmda_rise_fac_q <= '1;
			nmda_fall_fac_q <= '1;
			shutdown_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				amnm_pkg::REG_AMPA_STEP:      ampa_step_q     <= cfg_data;
				amnm_pkg::REG_NMDA_STEP:      nmda_step_q     <= cfg_data;
				amnm_pkg::REG_REVERSAL:       reversal_q      <= cfg_data[amnm_pkg::V_W-1:0];
				amnm_pkg::REG_AMPA_RISE_FAC:  ampa_rise_fac_q <= cfg_data[amnm_pkg::F_W-1:0];
				amnm_pkg::REG_AMPA_FALL_FAC:  ampa_fall_fac_q <= cfg_data[amnm_pkg::F_W-1:0];
				amnm_pkg::REG_NMDA_RISE_FAC:  nmda_rise_fac_q <= cfg_data[amnm_pkg::F_W-1:0];
				amnm_pkg::REG_NMDA_FALL_FAC:  nmda_fall_fac_q <= cfg_data[amnm_pkg::F_W-1:0];
				amnm_pkg::REG_SHUTDOWN_TICKS: shutdown_q <= cfg_data[amnm_pkg::TICK_W-1:0];
			endcase
		end
	end

	// Sequencer and synapse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= amnm_pkg::ST_IDLE;
			mode_spike_q     <= 1'b0;
			k_q              <= 1'b0;
			uop_q            <= '0;
			phase_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			ampa_rise_g_q[0] <= '0;
			ampa_rise_g_q[1] <= '0;
			ampa_fall_g_q[0] <= '0;
			ampa_fall_g_q[1] <= '0;
			nmda_rise_g_q[0] <= '0;
			nmda_rise_g_q[1] <= '0;
			nmda_fall_g_q[0] <= '0;
			nmda_fall_g_q[1] <= '0;
			ticks_q          <= '0;
			active_q         <= 1'b0;
		end else begin
			// drop the output beat once taken, reload from a finished item
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				amnm_pkg::ST_IDLE: begin
					if (in_take) begin
						mode_spike_q <= operation;
						k_q          <= 1'b0;
						uop_q        <= '0;
						phase_q      <= 1'b0;
						if (operation) begin
							ticks_q  <= '0;
							active_q <= 1'b1;
						end
						state_q <= (operation || active_q) ? amnm_pkg::ST_RUN
							: amnm_pkg::ST_DONE;
					end
				end
				amnm_pkg::ST_RUN: begin
					if (is_mult && !phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (uop_last) begin
							uop_q <= '0;
							if (mode_spike_q || k_q) begin
								state_q <= amnm_pkg::ST_DONE;
							end else begin
								k_q <= 1'b1;
							end
							// advance the tick count after the second step
							if (!mode_spike_q && k_q) begin
								ticks_q  <= ticks_next;
								active_q <= !(ticks_next > shutdown_q);
							end
						end else begin
							uop_q <= uop_q + 1'b1;
						end
					end
				end
				amnm_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= amnm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= amnm_pkg::ST_IDLE;
				end
			endcase

			// write back decays and spike steps
			if (exec && (uop.kind == amnm_pkg::U_DECAY)) begin
				unique case (uop.sel)
					amnm_pkg::G_AMPA_RISE: ampa_rise_g_q[k_q] <= g_dec;
					amnm_pkg::G_AMPA_FALL: ampa_fall_g_q[k_q] <= g_dec;
					amnm_pkg::G_NMDA_RISE: nmda_rise_g_q[k_q] <= g_dec;
					amnm_pkg::G_NMDA_FALL: nmda_fall_g_q[k_q] <= g_dec;
				endcase
			end else if (exec && (uop.kind == amnm_pkg::U_STEP)) begin
				unique case (uop.sel)
					amnm_pkg::G_AMPA_RISE: begin
						ampa_rise_g_q[0] <= amnm_pkg::sat_add_g(g_sel0, step_cur);
						ampa_rise_g_q[1] <= amnm_pkg::sat_add_g(g_sel1, g_dec);
					end
					amnm_pkg::G_AMPA_FALL: begin
						ampa_fall_g_q[0] <= amnm_pkg::sat_add_g(g_sel0, step_cur);
						ampa_fall_g_q[1] <= amnm_pkg::sat_add_g(g_sel1, g_dec);
					end
					amnm_pkg::G_NMDA_RISE: begin
						nmda_rise_g_q[0] <= amnm_pkg::sat_add_g(g_sel0, step_cur);
						nmda_rise_g_q[1] <= amnm_pkg::sat_add_g(g_sel1, g_dec);
					end
					amnm_pkg::G_NMDA_FALL: begin
						nmda_fall_g_q[0] <= amnm_pkg::sat_add_g(g_sel0, step_cur);
						nmda_fall_g_q[1] <= amnm_pkg::sat_add_g(g_sel1, g_dec);
					end
				endcase
			end
		end
	end

	// Working datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		idx_q  <= idx_prod[amnm_pkg::V_W +: IDX_W];
		mg_q   <= mg_rom[idx_q];

		// capture the item, clear the currents
		if (in_take) begin
			v_now_q  <= v_now;
			v_next_q <= v_next;
			w_q      <= syn_weight;
			cur_q[0] <= '0;
			cur_q[1] <= '0;
		end

		if (exec) begin
			unique case (uop.kind)
				amnm_pkg::U_DIFF: begin
					diff_q  <= {1'b0, fall_cur} - {1'b0, rise_cur};
					drive_q <= {reversal_q[amnm_pkg::V_W-1], reversal_q}
						- {v_sel[amnm_pkg::V_W-1], v_sel};
				end
				amnm_pkg::U_DRV: begin
					t_q <= prod_q[amnm_pkg::W_FRAC +: amnm_pkg::T_W];
				end
				amnm_pkg::U_LO: begin
					acc_q <= prod_ext;
				end
				amnm_pkg::U_HI_T: begin
					t_q <= acc_hi_sum[amnm_pkg::MG_FRAC +: amnm_pkg::T_W];
				end
				amnm_pkg::U_HI_W: begin
					acc_q <= acc_hi_sum;
				end
				amnm_pkg::U_ADD: begin
					if (uop.nmda) begin
						cur_q[k_q] <= amnm_pkg::sat_out(sum_total);
					end else begin
						sum_q <= acc_term;
					end
				end
				default: begin
				end
			endcase
		end

		// hand the finished result to the output register
		if (out_load) begin
			current_now_q  <= cur_q[0];
			current_next_q <= cur_q[1];
			is_active_q    <= active_q;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the AMPA/NMDA synapse step unit with a bit-exact scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int     MG_DEPTH      = 256;
	localparam int     MG_CONC       = 1;
	localparam longint EXP_SCALE_Q24 = 64'sd1500673;
	localparam longint CUR_MAX       = (64'sd1 <<< 47) - 64'sd1;
	localparam longint CUR_MIN       = -(64'sd1 <<< 47);
	localparam logic   OP_TICK       = 1'b0;
	localparam logic   OP_SPIKE      = 1'b1;
	localparam int     CYCLE_LIMIT   = 3000000;
	localparam int     PHASE_ITEMS   = 250;

	typedef struct {
		logic signed [amnm_pkg::OUT_W-1:0] cur_now;
		logic signed [amnm_pkg::OUT_W-1:0] cur_next;
		logic                              active_out;
	} synapse_result_t;

	typedef struct {
		logic [31:0] ampa_step;
		logic [31:0] nmda_step;
		logic [15:0] reversal;
		logic [15:0] ampa_rise_fac;
		logic [15:0] ampa_fall_fac;
		logic [15:0] nmda_rise_fac;
		logic [15:0] nmda_fall_fac;
		logic [23:0] shutdown;
	} syn_cfg_t;

	// Mirror of the synapse state; predicts currents per accepted beat
	class synapse_scoreboard;
		logic [31:0]        ampa_step, nmda_step;
		logic signed [15:0] reversal;
		logic [15:0]        ampa_rise_f, ampa_fall_f, nmda_rise_f, nmda_fall_f;
		logic [23:0]        shutdown;
		logic [31:0]        ampa_rise_g[2], ampa_fall_g[2], nmda_rise_g[2], nmda_fall_g[2];
		logic [23:0]        ticks;
		logic               active;
		longint             mg_block[MG_DEPTH];
		synapse_result_t    currents_due[$];
		int                 failures;

		function new();
			ampa_step = '0;
			nmda_step = '0;
			reversal = '0;
			ampa_rise_f = 16'hFFFF;
			ampa_fall_f = 16'hFFFF;
			nmda_rise_f = 16'hFFFF;
			nmda_fall_f = 16'hFFFF;
			shutdown = '0;
			for (int k = 0; k < 2; k++) begin
				ampa_rise_g[k] = '0;
				ampa_fall_g[k] = '0;
				nmda_rise_g[k] = '0;
				nmda_fall_g[k] = '0;
			end
			ticks = '0;
			active = 1'b0;
			failures = 0;
			build_block_table();
		endfunction

		function longint unsigned int_sqrt(longint unsigned x_in);
			longint unsigned x, r, b;
			x = x_in;
			r = 0;
			b = 64'd1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Magnesium block 1 / (1 + [Mg]/3.57 * exp(-0.062 V)) in unsigned Q1.16 per voltage bin
		function void build_block_table();
			longint unsigned root_q30[16];
			longint unsigned prev, mgq, frac, m, pw, den;
			longint vq, e, n, sh;
			prev = 64'd1 << 31;
			mgq = (64'(MG_CONC) * 64'd6553600 + 64'd178) / 64'd357;
			for (int j = 0; j < 16; j++) begin
				prev = int_sqrt(prev << 30);
				root_q30[j] = prev;
			end
			for (int i = 0; i < MG_DEPTH; i++) begin
				vq = -64'sd32768 + longint'((64'(i) * 64'd65536) / 64'(MG_DEPTH));
				e = (-vq * EXP_SCALE_Q24) >>> 16;
				n = e >>> 16;
				frac = longint'(e - n * 64'sd65536);
				m = 64'd1 << 30;
				for (int j = 0; j < 16; j++)
					if (frac[15-j])
						m = (m * root_q30[j]) >> 30;
				sh = 64'sd14 - n;
				if (sh < 0)
					sh = 0;
				pw = (sh > 63) ? 64'd0 : (m >> sh);
				den = 64'd65536 + ((pw * mgq) >> 16);
				mg_block[i] = longint'(((64'd1 << 32) + den / 64'd2) / den);
			end
		endfunction

		function void set_reg(logic [amnm_pkg::CFG_IDX_W-1:0] idx,
			logic [amnm_pkg::CFG_W-1:0] data);
			case (idx)
				amnm_pkg::REG_AMPA_STEP:      ampa_step = data;
				amnm_pkg::REG_NMDA_STEP:      nmda_step = data;
				amnm_pkg::REG_REVERSAL:       reversal = data[15:0];
				amnm_pkg::REG_AMPA_RISE_FAC:  ampa_rise_f = data[15:0];
				amnm_pkg::REG_AMPA_FALL_FAC:  ampa_fall_f = data[15:0];
				amnm_pkg::REG_NMDA_RISE_FAC:  nmda_rise_f = data[15:0];
				amnm_pkg::REG_NMDA_FALL_FAC:  nmda_fall_f = data[15:0];
				amnm_pkg::REG_SHUTDOWN_TICKS: shutdown = data[23:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] decayed(logic [31:0] g, logic [15:0] f);
			return 32'((64'(g) * 64'(f)) >> 16);
		endfunction

		function logic [31:0] stepped(logic [31:0] g, longint unsigned add);
			longint unsigned s;
			s = 64'(g) + add;
			return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function longint chan_term(logic [31:0] rise, logic [31:0] fall, longint drive,
			logic [15:0] w, bit use_mg, longint mg);
			longint diff, t;
			diff = longint'(fall) - longint'(rise);
			t = (diff * drive) >>> 8;
			if (use_mg)
				t = (t * mg) >>> 16;
			return (t * longint'(w)) >>> 8;
		endfunction

		// Update state for one beat and queue the currents it must produce
		function void predict_currents(logic op, logic signed [15:0] vn,
			logic signed [15:0] vx, logic [15:0] w);
			synapse_result_t r;
			longint volt[2];
			longint cur[2];
			longint drive, sum;
			int idx;
			cur[0] = 0;
			cur[1] = 0;
			if (op == OP_SPIKE) begin
				ampa_rise_g[0] = stepped(ampa_rise_g[0], 64'(ampa_step));
				ampa_fall_g[0] = stepped(ampa_fall_g[0], 64'(ampa_step));
				ampa_rise_g[1] = stepped(ampa_rise_g[1],
					(64'(ampa_step) * 64'(ampa_rise_f)) >> 16);
				ampa_fall_g[1] = stepped(ampa_fall_g[1],
					(64'(ampa_step) * 64'(ampa_fall_f)) >> 16);
				nmda_rise_g[0] = stepped(nmda_rise_g[0], 64'(nmda_step));
				nmda_fall_g[0] = stepped(nmda_fall_g[0], 64'(nmda_step));
				nmda_rise_g[1] = stepped(nmda_rise_g[1],
					(64'(nmda_step) * 64'(nmda_rise_f)) >> 16);
				nmda_fall_g[1] = stepped(nmda_fall_g[1],
					(64'(nmda_step) * 64'(nmda_fall_f)) >> 16);
				ticks = '0;
				active = 1'b1;
			end else if (active) begin
				volt[0] = vn;
				volt[1] = vx;
				for (int k = 0; k < 2; k++) begin
					ampa_rise_g[k] = decayed(ampa_rise_g[k], ampa_rise_f);
					ampa_fall_g[k] = decayed(ampa_fall_g[k], ampa_fall_f);
					nmda_rise_g[k] = decayed(nmda_rise_g[k], nmda_rise_f);
					nmda_fall_g[k] = decayed(nmda_fall_g[k], nmda_fall_f);
					drive = longint'(reversal) - volt[k];
					idx = int'(((volt[k] + 64'sd32768) * MG_DEPTH) >>> 16);
					if (idx >= MG_DEPTH)
						idx = MG_DEPTH - 1;
					sum = chan_term(ampa_rise_g[k], ampa_fall_g[k], drive, w, 1'b0, 0)
						+ chan_term(nmda_rise_g[k], nmda_fall_g[k], drive, w, 1'b1,
						mg_block[idx]);
					if (sum > CUR_MAX)
						sum = CUR_MAX;
					if (sum < CUR_MIN)
						sum = CUR_MIN;
					cur[k] = sum;
				end
				if (ticks != 24'hFF_FFFF)
					ticks = ticks + 24'd1;
				if (ticks > shutdown)
					active = 1'b0;
			end
			r.cur_now = cur[0][amnm_pkg::OUT_W-1:0];
			r.cur_next = cur[1][amnm_pkg::OUT_W-1:0];
			r.active_out = active;
			currents_due.push_back(r);
		endfunction

		function void mismatch(string field, longint want, longint got);
			failures++;
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
		endfunction

		// Compare one output beat against the oldest prediction
		function void check_currents(logic signed [amnm_pkg::OUT_W-1:0] cn,
			logic signed [amnm_pkg::OUT_W-1:0] cx, logic act);
			synapse_result_t e;
			if (currents_due.size() == 0) begin
				failures++;
				$error("output beat with no item pending: now %0d next %0d active %0b",
					cn, cx, act);
				return;
			end
			e = currents_due.pop_front();
			if (cn !== e.cur_now)
				mismatch("current_now", longint'(e.cur_now), longint'(cn));
			if (cx !== e.cur_next)
				mismatch("current_next", longint'(e.cur_next), longint'(cx));
			if (act !== e.active_out)
				mismatch("is_active", longint'(e.active_out), longint'(act));
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [amnm_pkg::CFG_IDX_W-1:0]    cfg_index = amnm_pkg::REG_AMPA_STEP;
	logic [amnm_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic                              operation = OP_TICK;
	logic signed [amnm_pkg::V_W-1:0]   v_now = '0;
	logic signed [amnm_pkg::V_W-1:0]   v_next = '0;
	logic [amnm_pkg::W_W-1:0]          syn_weight = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [amnm_pkg::OUT_W-1:0] current_now;
	logic signed [amnm_pkg::OUT_W-1:0] current_next;
	logic                              is_active;

	synapse_scoreboard sb;
	bit                rush = 1'b0;
	int                cycles = 0;

	ampa_nmda_synapse_step_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.v_now        (v_now),
		.v_next       (v_next),
		.syn_weight   (syn_weight),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.current_now  (current_now),
		.current_next (current_next),
		.is_active    (is_active)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		return rush ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic signed [15:0] pick_volt();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 38400)) - 25600);
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0020_0000);
		endcase
	endfunction

	function automatic logic [15:0] pick_factor();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(16'hC000, 16'hFFFF));
		endcase
	endfunction

	function automatic syn_cfg_t make_cfg(logic [31:0] a, logic [31:0] n, logic [15:0] rev,
		logic [15:0] ar, logic [15:0] af, logic [15:0] nr, logic [15:0] nf, logic [23:0] sd);
		syn_cfg_t s;
		s.ampa_step = a;
		s.nmda_step = n;
		s.reversal = rev;
		s.ampa_rise_fac = ar;
		s.ampa_fall_fac = af;
		s.nmda_rise_fac = nr;
		s.nmda_fall_fac = nf;
		s.shutdown = sd;
		return s;
	endfunction

	function automatic syn_cfg_t pick_settings();
		logic [15:0] rev;
		logic [23:0] sd;
		case ($urandom_range(0, 5))
			0: rev = 16'h8000;
			1: rev = 16'h7FFF;
			2: rev = 16'($urandom);
			default: rev = 16'(int'($urandom_range(0, 20480)) - 20480);
		endcase
		case ($urandom_range(0, 5))
			0: sd = 24'd0;
			1: sd = 24'hFF_FFFF;
			2: sd = 24'($urandom);
			default: sd = 24'($urandom_range(1, 40));
		endcase
		return make_cfg(pick_step(), pick_step(), rev, pick_factor(), pick_factor(),
			pick_factor(), pick_factor(), sd);
	endfunction

	// Leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(logic [amnm_pkg::CFG_IDX_W-1:0] idx,
		logic [amnm_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Junk in the unused upper bits must be dropped by the block
	task automatic apply_settings(syn_cfg_t s);
		write_reg(amnm_pkg::REG_AMPA_STEP, s.ampa_step);
		write_reg(amnm_pkg::REG_NMDA_STEP, s.nmda_step);
		write_reg(amnm_pkg::REG_REVERSAL, {16'($urandom), s.reversal});
		write_reg(amnm_pkg::REG_AMPA_RISE_FAC, {16'($urandom), s.ampa_rise_fac});
		write_reg(amnm_pkg::REG_AMPA_FALL_FAC, {16'($urandom), s.ampa_fall_fac});
		write_reg(amnm_pkg::REG_NMDA_RISE_FAC, {16'($urandom), s.nmda_rise_fac});
		write_reg(amnm_pkg::REG_NMDA_FALL_FAC, {16'($urandom), s.nmda_fall_fac});
		write_reg(amnm_pkg::REG_SHUTDOWN_TICKS, {8'($urandom), s.shutdown});
		cfg_we <= 1'b0;
	endtask

	// Offer one input beat after a random gap and hold it until taken
	task automatic push_item(logic op, logic signed [15:0] vn, logic signed [15:0] vx,
		logic [15:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		v_now <= vn;
		v_next <= vx;
		syn_weight <= w;
		do @(posedge clk); while (in_stall);
		sb.predict_currents(op, vn, vx, w);
	endtask

	// Hold off the sender until every predicted beat has come out
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (sb.currents_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly spike-then-ticks trains with random content, some loose beats
	task automatic run_phase(int quota);
		int counted, burst, j;
		logic op;
		counted = 0;
		while (counted < quota) begin
			rush = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 8) begin
				push_item(OP_SPIKE, pick_volt(), pick_volt(), pick_weight());
				counted++;
				if (sb.shutdown < 22)
					burst = $urandom_range(1, sb.shutdown + 3);
				else
					burst = $urandom_range(1, 25);
				for (j = 0; j < burst; j++) begin
					push_item(OP_TICK, pick_volt(), pick_volt(), pick_weight());
					counted++;
				end
			end else begin
				op = 1'($urandom_range(0, 1));
				push_item(op, pick_volt(), pick_volt(), pick_weight());
				counted++;
			end
		end
		rush = 1'b0;
	endtask

	// Output side: random stall per beat, check each accepted beat
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_currents(current_now, current_next, is_active);
		end
	end

	initial begin
		int p;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle tick, zero-sized spike, immediate shutdown
		push_item(OP_TICK, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0000);
		push_item(OP_TICK, 16'sh7FFF, 16'sh8000, 16'hFFFF);
		wait_results_done();

		// Moderate kinetics: trains, stacked spikes, decay to shutdown
		apply_settings(make_cfg(32'h0004_0000, 32'h0008_0000, 16'h0000,
			16'hE000, 16'hFC00, 16'hF000, 16'hFF00, 24'd6));
		push_item(OP_SPIKE, 16'sh1234, 16'sh4321, 16'h0100);
		push_item(OP_TICK, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		push_item(OP_TICK, 16'sh0000, 16'sh0000, 16'h0000);
		push_item(OP_TICK, -16'sd16640, -16'sd16384, 16'h0100);
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0100);
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0100);
		push_item(OP_TICK, 16'sh7FFF, 16'sh8000, 16'h8000);
		repeat (6) push_item(OP_TICK, -16'sd17920, -16'sd17664, 16'h0200);
		push_item(OP_TICK, 16'sh0000, 16'sh0000, 16'hFFFF);
		wait_results_done();

		// Full-scale steps: saturating adds and negative current clamp
		apply_settings(make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 24'd3));
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0000);
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0000);
		push_item(OP_TICK, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
		push_item(OP_TICK, 16'sh8000, 16'sh8000, 16'hFFFF);
		wait_results_done();

		// Positive current clamp
		apply_settings(make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 24'd3));
		push_item(OP_SPIKE, 16'sh0000, 16'sh0000, 16'h0000);
		push_item(OP_TICK, 16'sh8000, 16'sh8000, 16'hFFFF);
		push_item(OP_TICK, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		wait_results_done();

		// Random phases, each with fresh settings applied while idle
		for (p = 0; p < 7; p++) begin
			case (p)
				0: apply_settings(make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF,
					16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF));
				1: apply_settings(make_cfg(32'h0001_0000, 32'h0002_0000, 16'h8000,
					16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0));
				default: apply_settings(pick_settings());
			endcase
			run_phase(PHASE_ITEMS);
			wait_results_done();
		end

		repeat (100) @(posedge clk);
		if (sb.currents_due.size() != 0) begin
			$error("%0d predicted output beats never arrived", sb.currents_due.size());
			sb.failures++;
		end
		if (sb.failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
